// ===== design/assert_macros.svh =====
// Assertion helpers; empty when synthesised.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_SAME(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== design/plt_pkg.sv =====
`default_nettype none

package plt_pkg;

  localparam int WL_W       = 16;
  localparam int REFL_W     = 16;
  localparam int CNT_CFG_W  = 7;
  localparam int STATUS_W   = 3;
  localparam int DIVIDEND_W = 32;
  localparam int DIV_STEPS  = 32;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_INTERP    = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_LOW       = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_HIGH      = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_BAD_ORDER = 3'd4;

  typedef struct packed {
    logic [WL_W-1:0]   wl;
    logic [REFL_W-1:0] refl;
  } plt_point_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIRST,
    S_LAST,
    S_SEARCH,
    S_MUL,
    S_SUM,
    S_DIV,
    S_DONE
  } plt_state_e;

endpackage

`default_nettype wire

// ===== design/piecewise_linear_table_interp.sv =====
// Write request: taken while the controller is idle, no response; writes may run back to back.
// Query: an empty table ends at once; else the first point is read for the low clamp, the last for
// the high clamp, then the one-point-per-cycle search walks the segments, ending on a bad-order one
// or running multiply, sum and the 32-step divider. The controller turns ready again as the result
// is loaded, later while a held result waits. One query in flight at a time.
// Reset clears the point count, the controller and the output valid; point memory not cleared.
`default_nettype none

`include "assert_macros.svh"

module piecewise_linear_table_interp #(
  parameter int MAX_POINTS = 64
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [plt_pkg::CNT_CFG_W-1:0]   cfg_wdata_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic                            opcode_i,
  input  wire logic [5:0]                      point_index_i,
  input  wire logic [plt_pkg::WL_W-1:0]        point_wavelength_i,
  input  wire logic [plt_pkg::REFL_W-1:0]      point_reflectance_i,
  input  wire logic [plt_pkg::WL_W-1:0]        query_wavelength_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [plt_pkg::REFL_W-1:0]           reflectance_o,
  output logic [plt_pkg::STATUS_W-1:0]         status_o
);

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);

  plt_pkg::plt_state_e state_q, state_d;

  logic [plt_pkg::CNT_CFG_W-1:0] point_count_q;
  logic [CNT_W-1:0]              n_w;
  logic [IDX_W-1:0]              last_w;
  logic [IDX_W-1:0]              last_q;
  logic [IDX_W-1:0]              k_q;
  logic [plt_pkg::WL_W-1:0]      q_q;
  plt_pkg::plt_point_t           prev_q;
  plt_pkg::plt_point_t           cur_q;
  logic [31:0]                   p0_q;
  logic [31:0]                   p1_q;
  logic [plt_pkg::WL_W-1:0]      den_q;
  logic [plt_pkg::REFL_W-1:0]    res_q;
  logic [plt_pkg::STATUS_W-1:0]  st_q;
  logic                          out_valid_q;
  logic [plt_pkg::REFL_W-1:0]    out_refl_q;
  logic [plt_pkg::STATUS_W-1:0]  out_st_q;

  logic                          accept;
  logic                          is_query;
  logic                          idx_ok;
  logic                          mem_we;
  logic [IDX_W-1:0]              mem_raddr;
  plt_pkg::plt_point_t           mem_wdata;
  plt_pkg::plt_point_t           rd;
  logic                          div_start;
  logic                          div_done;
  logic [plt_pkg::REFL_W-1:0]    div_quot;
  logic [plt_pkg::DIVIDEND_W-1:0] num_w;
  logic                          hit;
  logic                          bad;
  logic                          out_free;

  assign n_w = (32'(point_count_q) > 32'(MAX_POINTS)) ? CNT_W'(MAX_POINTS)
                                                      : CNT_W'(point_count_q);
  assign last_w   = IDX_W'(n_w - CNT_W'(1));
  assign accept   = in_valid_i && in_ready_o;
  assign is_query = opcode_i == plt_pkg::OP_QUERY;
  assign idx_ok   = 32'(point_index_i) < 32'(MAX_POINTS);
  assign mem_we   = accept && !is_query && idx_ok;
  assign mem_wdata = '{wl: point_wavelength_i, refl: point_reflectance_i};
  assign hit      = q_q < rd.wl;
  assign bad      = (rd.wl <= prev_q.wl) || (q_q < prev_q.wl);
  assign num_w    = plt_pkg::DIVIDEND_W'(33'(p0_q) + 33'(p1_q));
  assign out_free = !out_valid_q || out_ready_i;

  plt_mem #(
    .DEPTH (MAX_POINTS),
    .AW    (IDX_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (IDX_W'(point_index_i)),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (rd)
  );

  plt_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (num_w),
    .divisor_i  (den_q),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      plt_pkg::S_IDLE: begin
        if (accept && is_query) begin
          state_d = (n_w == '0) ? plt_pkg::S_DONE : plt_pkg::S_FIRST;
        end
      end
      plt_pkg::S_FIRST:  state_d = (q_q <= rd.wl) ? plt_pkg::S_DONE : plt_pkg::S_LAST;
      plt_pkg::S_LAST:   state_d = (q_q >= rd.wl) ? plt_pkg::S_DONE : plt_pkg::S_SEARCH;
      plt_pkg::S_SEARCH: begin
        if (hit) begin
          state_d = bad ? plt_pkg::S_DONE : plt_pkg::S_MUL;
        end
      end
      plt_pkg::S_MUL:    state_d = plt_pkg::S_SUM;
      plt_pkg::S_SUM:    state_d = plt_pkg::S_DIV;
      plt_pkg::S_DIV:    state_d = div_done ? plt_pkg::S_DONE : plt_pkg::S_DIV;
      plt_pkg::S_DONE:   state_d = out_free ? plt_pkg::S_IDLE : plt_pkg::S_DONE;
      default:           state_d = plt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    div_start  = 1'b0;
    mem_raddr  = '0;
    unique case (state_q)
      plt_pkg::S_IDLE:   in_ready_o = 1'b1;
      plt_pkg::S_FIRST:  mem_raddr  = last_q;
      plt_pkg::S_LAST:   mem_raddr  = IDX_W'(1);
      plt_pkg::S_SEARCH: mem_raddr  = k_q + IDX_W'(1);
      plt_pkg::S_SUM:    div_start  = 1'b1;
      plt_pkg::S_MUL, plt_pkg::S_DIV, plt_pkg::S_DONE: begin
        mem_raddr = '0;
      end
      default:           mem_raddr  = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= plt_pkg::S_IDLE;
      point_count_q <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        point_count_q <= cfg_wdata_i;
      end
      if (state_q == plt_pkg::S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      plt_pkg::S_IDLE: begin
        q_q    <= query_wavelength_i;
        last_q <= last_w;
        res_q  <= '0;
        st_q   <= plt_pkg::STATUS_EMPTY;
      end
      plt_pkg::S_FIRST: begin
        prev_q <= rd;
        res_q  <= rd.refl;
        st_q   <= plt_pkg::STATUS_LOW;
      end
      plt_pkg::S_LAST: begin
        k_q   <= IDX_W'(1);
        res_q <= rd.refl;
        st_q  <= plt_pkg::STATUS_HIGH;
      end
      plt_pkg::S_SEARCH: begin
        if (hit) begin
          cur_q <= rd;
          res_q <= prev_q.refl;
          st_q  <= plt_pkg::STATUS_BAD_ORDER;
        end else begin
          prev_q <= rd;
          k_q    <= k_q + IDX_W'(1);
        end
      end
      plt_pkg::S_MUL: begin
        p0_q  <= 32'(prev_q.refl) * 32'(cur_q.wl - q_q);
        p1_q  <= 32'(cur_q.refl) * 32'(q_q - prev_q.wl);
        den_q <= cur_q.wl - prev_q.wl;
      end
      plt_pkg::S_DIV: begin
        if (div_done) begin
          res_q <= div_quot;
          st_q  <= plt_pkg::STATUS_INTERP;
        end
      end
      plt_pkg::S_DONE: begin
        if (out_free) begin
          out_refl_q <= res_q;
          out_st_q   <= st_q;
        end
      end
      default: begin
        res_q <= res_q;
      end
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign reflectance_o = out_refl_q;
  assign status_o      = out_st_q;

  `ASSERT_SAME(a_div_done_in_div, clk_i, rst_ni, div_done, state_q == plt_pkg::S_DIV)
  `ASSERT_SAME(a_search_in_range, clk_i, rst_ni, state_q == plt_pkg::S_SEARCH, k_q <= last_q)
  `ASSERT_NEXT(a_done_loads_out, clk_i, rst_ni, state_q == plt_pkg::S_DONE && !out_valid_q, state_q == plt_pkg::S_IDLE && out_valid_q)

endmodule

`default_nettype wire

// ===== design/plt_mem.sv =====
`default_nettype none

module plt_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic                clk_i,
  input  wire logic                we_i,
  input  wire logic [AW-1:0]       waddr_i,
  input  wire plt_pkg::plt_point_t wdata_i,
  input  wire logic [AW-1:0]       raddr_i,
  output plt_pkg::plt_point_t      rdata_o
);

  plt_pkg::plt_point_t mem [DEPTH];
  plt_pkg::plt_point_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== design/plt_div.sv =====
`default_nettype none

// radix-2 restoring divide, one quotient bit per cycle
module plt_div (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  input  wire logic [plt_pkg::DIVIDEND_W-1:0]   dividend_i,
  input  wire logic [plt_pkg::WL_W-1:0]         divisor_i,
  output logic                                  done_o,
  output logic [plt_pkg::REFL_W-1:0]            quotient_o
);

  logic                              busy_q;
  logic                              done_q;
  logic [plt_pkg::DIV_CNT_W-1:0]     cnt_q;
  logic [plt_pkg::WL_W-1:0]          rem_q;
  logic [plt_pkg::WL_W-1:0]          rem_d;
  logic [plt_pkg::DIVIDEND_W-1:0]    dvd_q;
  logic [plt_pkg::WL_W-1:0]          den_q;
  logic [plt_pkg::WL_W:0]            rem_sh;
  logic                              ge;
  logic                              last_step;

  assign rem_sh    = {rem_q, dvd_q[plt_pkg::DIVIDEND_W-1]};
  assign ge        = rem_sh >= {1'b0, den_q};
  assign rem_d     = ge ? plt_pkg::WL_W'(rem_sh - {1'b0, den_q})
                        : rem_sh[plt_pkg::WL_W-1:0];
  assign last_step = cnt_q == plt_pkg::DIV_CNT_W'(plt_pkg::DIV_STEPS - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && last_step;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + plt_pkg::DIV_CNT_W'(1);
        if (last_step) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvd_q <= dividend_i;
      den_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      dvd_q <= {dvd_q[plt_pkg::DIVIDEND_W-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q[plt_pkg::REFL_W-1:0];

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int TABLE_DEPTH = 64;
  localparam int unsigned ITEM_TARGET = 1850;
  localparam int unsigned PHASE_TRAFFIC = 70;
  localparam int unsigned DRAIN_CYCLES = 150;
  localparam int unsigned CYCLE_LIMIT = 1_500_000;
  localparam int NUM_PRESETS = 10;
  localparam logic [plt_pkg::CNT_CFG_W-1:0] PRESET_COUNTS [NUM_PRESETS] =
    '{7'd64, 7'd127, 7'd1, 7'd2, 7'd0, 7'd3, 7'd65, 7'd16, 7'd5, 7'd33};

  typedef struct packed {
    logic                       op;
    logic [5:0]                 idx;
    logic [plt_pkg::WL_W-1:0]   pwl;
    logic [plt_pkg::REFL_W-1:0] prefl;
    logic [plt_pkg::WL_W-1:0]   qwl;
  } table_request_t;

  typedef struct packed {
    logic [plt_pkg::REFL_W-1:0]   refl;
    logic [plt_pkg::STATUS_W-1:0] status;
  } lookup_answer_t;

  class table_scoreboard;
    logic [plt_pkg::WL_W-1:0]      wl_tab [TABLE_DEPTH];
    logic [plt_pkg::REFL_W-1:0]    refl_tab [TABLE_DEPTH];
    logic [plt_pkg::CNT_CFG_W-1:0] point_count;
    lookup_answer_t                answers_due [$];
    int unsigned                   mismatches;
    int unsigned                   writes_seen;
    int unsigned                   lookups_seen;
    int unsigned                   status_hits [5];

    function new();
      point_count = '0;
      mismatches = 0;
      writes_seen = 0;
      lookups_seen = 0;
      foreach (status_hits[k]) status_hits[k] = 0;
    endfunction

    function int unsigned points_in_use();
      return (point_count > TABLE_DEPTH) ? TABLE_DEPTH : point_count;
    endfunction

    function int pending();
      return answers_due.size();
    endfunction

    function void set_count(logic [plt_pkg::CNT_CFG_W-1:0] v);
      point_count = v;
    endfunction

    function lookup_answer_t interpolate(logic [plt_pkg::WL_W-1:0] q);
      lookup_answer_t a;
      int unsigned n;
      longint unsigned x0, x1, y0, y1, num;
      bit found;
      a.refl = '0;
      a.status = plt_pkg::STATUS_EMPTY;
      n = points_in_use();
      found = 1'b0;
      if (n == 0) begin
        a.refl = '0;
        a.status = plt_pkg::STATUS_EMPTY;
      end else if (q <= wl_tab[0]) begin
        a.refl = refl_tab[0];
        a.status = plt_pkg::STATUS_LOW;
      end else if (q >= wl_tab[n-1]) begin
        a.refl = refl_tab[n-1];
        a.status = plt_pkg::STATUS_HIGH;
      end else begin
        for (int unsigned i = 0; i + 1 < n && !found; i++) begin
          if (q < wl_tab[i+1]) begin
            found = 1'b1;
            x0 = wl_tab[i];
            x1 = wl_tab[i+1];
            y0 = refl_tab[i];
            y1 = refl_tab[i+1];
            if (x1 <= x0 || q < x0) begin
              a.refl = y0[plt_pkg::REFL_W-1:0];
              a.status = plt_pkg::STATUS_BAD_ORDER;
            end else begin
              num = y0 * (x1 - q) + y1 * (q - x0);
              a.refl = plt_pkg::REFL_W'(num / (x1 - x0));
              a.status = plt_pkg::STATUS_INTERP;
            end
          end
        end
      end
      return a;
    endfunction

    function void note_request(table_request_t r);
      lookup_answer_t a;
      if (r.op == plt_pkg::OP_WRITE) begin
        wl_tab[r.idx] = r.pwl;
        refl_tab[r.idx] = r.prefl;
        writes_seen++;
      end else begin
        a = interpolate(r.qwl);
        answers_due = {answers_due, a};
        lookups_seen++;
        if (a.status < 5) status_hits[a.status]++;
      end
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= 50) $display("MISMATCH at %0t ns: %s", $time, msg);
    endtask

    task check_result(logic [plt_pkg::REFL_W-1:0] refl, logic [plt_pkg::STATUS_W-1:0] st);
      lookup_answer_t a;
      if (answers_due.size() == 0) begin
        report($sformatf("result with no request pending: refl %h status %0d", refl, st));
        return;
      end
      a = answers_due.pop_front();
      if (refl !== a.refl)
        report($sformatf("reflectance %h, expected %h", refl, a.refl));
      if (st !== a.status)
        report($sformatf("status %0d, expected %0d", st, a.status));
    endtask
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [plt_pkg::CNT_CFG_W-1:0] cfg_wdata_i;
  logic                          in_valid_i;
  logic                          in_ready_o;
  logic                          opcode_i;
  logic [5:0]                    point_index_i;
  logic [plt_pkg::WL_W-1:0]      point_wavelength_i;
  logic [plt_pkg::REFL_W-1:0]    point_reflectance_i;
  logic [plt_pkg::WL_W-1:0]      query_wavelength_i;
  logic                          out_valid_o;
  logic                          out_ready_i;
  logic [plt_pkg::REFL_W-1:0]    reflectance_o;
  logic [plt_pkg::STATUS_W-1:0]  status_o;

  table_scoreboard sb = new();
  int unsigned items_sent = 0;
  int unsigned count_settings = 0;
  int unsigned cycle_count = 0;
  int unsigned src_burst = 0;
  int unsigned sink_burst = 0;

  piecewise_linear_table_interp #(
    .MAX_POINTS(TABLE_DEPTH)
  ) i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .opcode_i           (opcode_i),
    .point_index_i      (point_index_i),
    .point_wavelength_i (point_wavelength_i),
    .point_reflectance_i(point_reflectance_i),
    .query_wavelength_i (query_wavelength_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .reflectance_o      (reflectance_o),
    .status_o           (status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic int unsigned draw_gap(ref int unsigned burst_left);
    if (burst_left != 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      burst_left = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 18);
  endfunction

  function automatic logic [plt_pkg::REFL_W-1:0] pick_level();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return plt_pkg::REFL_W'($urandom);
    endcase
  endfunction

  function automatic logic [plt_pkg::WL_W-1:0] pick_query(int unsigned n);
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (n == 0 || sel == 0) return plt_pkg::WL_W'($urandom);
    if (sel == 1) return $urandom_range(0, 1) ? '0 : '1;
    if (sel == 2) return sb.wl_tab[$urandom_range(0, n - 1)];
    return plt_pkg::WL_W'($urandom_range(sb.wl_tab[0], sb.wl_tab[n-1]));
  endfunction

  task automatic send_request(input table_request_t r);
    int unsigned gap;
    gap = draw_gap(src_burst);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= r.op;
    point_index_i <= r.idx;
    point_wavelength_i <= r.pwl;
    point_reflectance_i <= r.prefl;
    query_wavelength_i <= r.qwl;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    sb.note_request(r);
    items_sent++;
  endtask

  task automatic send_query(input logic [plt_pkg::WL_W-1:0] q);
    table_request_t r;
    r.op = plt_pkg::OP_QUERY;
    r.idx = 6'($urandom);
    r.pwl = plt_pkg::WL_W'($urandom);
    r.prefl = plt_pkg::REFL_W'($urandom);
    r.qwl = q;
    send_request(r);
  endtask

  task automatic send_write(input int unsigned idx, input logic [plt_pkg::WL_W-1:0] wl,
                            input logic [plt_pkg::REFL_W-1:0] refl);
    table_request_t r;
    r.op = plt_pkg::OP_WRITE;
    r.idx = 6'(idx);
    r.pwl = wl;
    r.prefl = refl;
    r.qwl = plt_pkg::WL_W'($urandom);
    send_request(r);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_point_count(input logic [plt_pkg::CNT_CFG_W-1:0] v);
    wait_idle();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_count(v);
    count_settings++;
  endtask

  // ascending table, sometimes dense, sometimes scrambled
  task automatic load_table(input int unsigned n);
    int unsigned step_max, wl;
    bit scrambled, dense;
    if (n == 0) return;
    scrambled = ($urandom_range(0, 7) == 0);
    dense = ($urandom_range(0, 3) == 0);
    step_max = dense ? $urandom_range(1, 8) : 65535 / n;
    wl = dense ? $urandom_range(0, 60000) : $urandom_range(0, step_max);
    for (int unsigned i = 0; i < n; i++) begin
      send_write(i, scrambled ? plt_pkg::WL_W'($urandom) : plt_pkg::WL_W'(wl), pick_level());
      wl += $urandom_range(1, step_max);
    end
  endtask

  task automatic run_traffic(input int unsigned items);
    int unsigned n, idx;
    for (int unsigned k = 0; k < items; k++) begin
      n = sb.points_in_use();
      if ($urandom_range(0, 7) != 0) begin
        send_query(pick_query(n));
      end else begin
        idx = $urandom_range(0, TABLE_DEPTH - 1);
        if (idx < n && $urandom_range(0, 3) != 0)
          send_write(idx, sb.wl_tab[idx], pick_level());
        else
          send_write(idx, plt_pkg::WL_W'($urandom), plt_pkg::REFL_W'($urandom));
      end
    end
  endtask

  task automatic directed_checks();
    send_query('0);
    send_query('1);
    send_write(0, '0, '1);
    send_write(TABLE_DEPTH - 1, '1, '0);
    send_write(1, '1, '0);
    set_point_count(7'd2);
    send_query('0);
    send_query('1);
    send_query(16'd1);
    send_query(16'hFFFE);
    send_query(16'h8000);
    set_point_count(7'd1);
    send_query('0);
    send_query(16'd40000);
    // second point at the same wavelength as the first
    send_write(1, '0, 16'h1234);
    set_point_count(7'd2);
    send_query('0);
    send_query(16'd5);
  endtask

  initial begin
    int unsigned phase;
    logic [plt_pkg::CNT_CFG_W-1:0] cnt;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    opcode_i = 1'b0;
    point_index_i = '0;
    point_wavelength_i = '0;
    point_reflectance_i = '0;
    query_wavelength_i = '0;
    out_ready_i = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed_checks();
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      if (phase < NUM_PRESETS)
        cnt = PRESET_COUNTS[phase];
      else if ($urandom_range(0, 3) == 0)
        cnt = plt_pkg::CNT_CFG_W'($urandom_range(0, 127));
      else
        cnt = plt_pkg::CNT_CFG_W'($urandom_range(1, 24));
      set_point_count(cnt);
      load_table(sb.points_in_use());
      run_traffic(PHASE_TRAFFIC);
      phase++;
    end
    wait_idle();

    $display("Sent %0d table writes and %0d lookups across %0d point-count settings.",
             sb.writes_seen, sb.lookups_seen, count_settings);
    $display("Lookups: %0d interpolated, %0d low, %0d high, %0d empty, %0d bad order.",
             sb.status_hits[0], sb.status_hits[1], sb.status_hits[2], sb.status_hits[3],
             sb.status_hits[4]);
    if (sb.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    int unsigned gap;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      gap = draw_gap(sink_burst);
      if (gap != 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      sb.check_result(reflectance_o, status_o);
    end
  end

endmodule
